[rtl/lphs_pkg.sv]
// Shared types, constants and helper functions for the linear-probe hash set.
// No dependencies; every other file of the block imports this package.
package lphs_pkg;

    // Table geometry and field widths
    localparam int MAX_SLOTS  = 1024;
    localparam int VALUE_BITS = 31;
    localparam int IDX_W      = $clog2(MAX_SLOTS);
    localparam int SIZE_W     = IDX_W + 1;
    localparam int BIT_W      = $clog2(VALUE_BITS);
    localparam int TAG_W      = 2;
    localparam int SLOT_W     = TAG_W + VALUE_BITS;
    localparam int OPC_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);
    localparam int RESET_SIZE = 16;

    // Operation codes as they arrive on the operation port
    localparam logic [OPC_W-1:0] OPC_LOOKUP = 2'd0;
    localparam logic [OPC_W-1:0] OPC_INSERT = 2'd1;
    localparam logic [OPC_W-1:0] OPC_DELETE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_RESIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_SIZE = 2'd1;

    typedef enum logic [TAG_W-1:0] {
        TAG_EMPTY = 2'd0,
        TAG_LIVE  = 2'd1,
        TAG_GRAVE = 2'd2
    } tag_t;

    typedef enum logic [1:0] {
        OP_LOOKUP,
        OP_INSERT,
        OP_DELETE,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic [VALUE_BITS-1:0] key;
    } cmd_t;

    typedef struct packed {
        logic              success;
        logic [IDX_W-1:0]  slot;
        logic              full_err;
        logic [SIZE_W-1:0] size;
        logic [SIZE_W-1:0] live;
        logic [SIZE_W-1:0] grave;
    } res_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD_OP,
        ST_LK_RD,
        ST_LK_CHK,
        ST_RS_RD,
        ST_RS_CHK,
        ST_MOD_RS,
        ST_RS_FRD,
        ST_RS_FCHK,
        ST_MOD_INS,
        ST_FREE_RD,
        ST_FREE_CHK,
        ST_DONE
    } eng_state_t;

    // Step a probe pointer by one with wrap at the table size
    function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] p,
                                                   input logic [SIZE_W-1:0] m);
        logic [SIZE_W-1:0] nxt;
        nxt = {1'b0, p} + SIZE_W'(1);
        return (nxt == m) ? '0 : nxt[IDX_W-1:0];
    endfunction

    // Bound a written table size to the legal range
    function automatic logic [SIZE_W-1:0] clip_size(input logic [CFG_DATA_W-1:0] v);
        logic [SIZE_W-1:0] r;
        if (v == '0)
            r = SIZE_W'(1);
        else if (v > CFG_DATA_W'(MAX_SLOTS))
            r = SIZE_W'(MAX_SLOTS);
        else
            r = SIZE_W'(v);
        return r;
    endfunction

endpackage

[rtl/lphs_front.sv]
// Front end: decodes incoming operations and holds them in a short command queue.
// Depends on lphs_pkg.
module lphs_front import lphs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [OPC_W-1:0]      operation,
    input  logic [VALUE_BITS-1:0] key_value,
    output logic                  cmd_valid,
    output cmd_t                  cmd,
    input  logic                  cmd_take
);

    cmd_t              q_reg [QDEPTH];
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    cmd_t              dec;
    logic              accept;
    logic              take;

    // Classify the operation code
    always_comb
    begin
        dec.key = key_value;
        unique case (operation)
            OPC_LOOKUP: dec.op = OP_LOOKUP;
            OPC_INSERT: dec.op = OP_INSERT;
            OPC_DELETE: dec.op = OP_DELETE;
            default:    dec.op = OP_NONE;
        endcase
    end

    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign accept    = push && !full;
    assign take      = cmd_take && cmd_valid;

    // Advance queue pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (accept)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        if (take)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        if (accept && !take)
            count_next = count_reg + QCNT_W'(1);
        else if (take && !accept)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the decoded transaction
    always_ff @(posedge clk)
    begin
        if (accept)
            q_reg[wr_ptr_reg] <= dec;
    end

endmodule

[rtl/lphs_resq.sv]
// Result queue: holds finished results until the consumer pops them.
// Depends on lphs_pkg.
module lphs_resq import lphs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic res_push,
    input  res_t res_in,
    output logic res_full,
    output logic empty,
    input  logic pop,
    output res_t res_out
);

    res_t              q_reg [QDEPTH];
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              wr;
    logic              rd;

    assign res_full = (count_reg == QCNT_W'(QDEPTH));
    assign empty    = (count_reg == '0);
    assign res_out  = q_reg[rd_ptr_reg];
    assign wr       = res_push && !res_full;
    assign rd       = pop && !empty;

    // Advance queue pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        if (rd)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        if (wr && !rd)
            count_next = count_reg + QCNT_W'(1);
        else if (rd && !wr)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the result transaction
    always_ff @(posedge clk)
    begin
        if (wr)
            q_reg[wr_ptr_reg] <= res_in;
    end

endmodule

[rtl/lphs_engine.sv]
// Back end: slot banks, serial key reduction, probe sequencer and resize walk.
// Depends on lphs_pkg.
module lphs_engine import lphs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  cmd_valid,
    input  cmd_t                  cmd,
    output logic                  cmd_take,
    output logic                  res_push,
    output res_t                  res,
    input  logic                  res_full
);

    localparam logic [SLOT_W-1:0] EMPTY_SLOT = {TAG_EMPTY, {VALUE_BITS{1'b0}}};

    // Slot banks
    logic [SLOT_W-1:0] bank_a_mem [MAX_SLOTS];
    logic [SLOT_W-1:0] bank_b_mem [MAX_SLOTS];
    logic [SLOT_W-1:0] a_q, b_q;
    logic              a_we, b_we;
    logic [IDX_W-1:0]  a_waddr, b_waddr, a_raddr, b_raddr;
    logic [SLOT_W-1:0] a_wdata, b_wdata;

    // Logical ports: active (source) bank and the other (destination) bank
    logic              act_we, dst_we, clr_we;
    logic [IDX_W-1:0]  act_waddr, dst_waddr, act_raddr, dst_raddr;
    logic [SLOT_W-1:0] act_wdata, dst_wdata;
    logic [SLOT_W-1:0] act_q, dst_q;

    eng_state_t            state_reg, state_next;
    op_t                   op_reg, op_next;
    logic [VALUE_BITS-1:0] key_reg, key_next;
    logic [VALUE_BITS-1:0] rs_key_reg, rs_key_next;
    logic [SIZE_W-1:0]     rem_reg, rem_next;
    logic [SIZE_W-1:0]     div_reg, div_next;
    logic [BIT_W-1:0]      bit_reg, bit_next;
    logic [IDX_W-1:0]      ptr_reg, ptr_next;
    logic [SIZE_W-1:0]     cnt_reg, cnt_next;
    logic                  free_found_reg, free_found_next;
    logic [IDX_W-1:0]      free_ptr_reg, free_ptr_next;
    logic [IDX_W-1:0]      rs_idx_reg, rs_idx_next;
    logic [SIZE_W-1:0]     rs_new_reg, rs_new_next;
    logic [SIZE_W-1:0]     rs_live_reg, rs_live_next;
    logic                  then_ins_reg, then_ins_next;
    logic [IDX_W-1:0]      clr_idx_reg, clr_idx_next;
    logic                  bank_reg, bank_next;
    logic [SIZE_W-1:0]     size_reg, size_next;
    logic [SIZE_W-1:0]     live_reg, live_next;
    logic [SIZE_W-1:0]     grave_reg, grave_next;
    logic                  auto_reg, auto_next;
    logic                  succ_reg, succ_next;
    logic [IDX_W-1:0]      slot_reg, slot_next;
    logic                  fullerr_reg, fullerr_next;

    // Decoded slot contents and conditions
    tag_t                  act_tag, dst_tag;
    logic [VALUE_BITS-1:0] act_key;
    logic                  hit, free_now, probe_last, rs_probe_last, rs_last;
    logic                  rs_adv;
    logic [IDX_W-1:0]      free_sel;
    logic [SIZE_W-1:0]     cnt_inc, live_dec;
    logic [SIZE_W:0]       live_x2, size_x2;
    logic [SIZE_W+2:0]     dec_x8;
    logic                  grow_ok, shrink_ok;
    logic [VALUE_BITS-1:0] mod_key;
    logic [SIZE_W:0]       mod_t, mod_sub;
    logic [SIZE_W-1:0]     rem_step;
    logic                  mod_last;
    logic                  init_wr;

    assign act_q   = bank_reg ? b_q : a_q;
    assign dst_q   = bank_reg ? a_q : b_q;
    assign act_tag = tag_t'(act_q[SLOT_W-1 -: TAG_W]);
    assign dst_tag = tag_t'(dst_q[SLOT_W-1 -: TAG_W]);
    assign act_key = act_q[VALUE_BITS-1:0];

    assign hit           = (act_tag == TAG_LIVE) && (act_key == key_reg);
    assign free_now      = free_found_reg || (act_tag != TAG_LIVE);
    assign free_sel      = free_found_reg ? free_ptr_reg : ptr_reg;
    assign cnt_inc       = cnt_reg + SIZE_W'(1);
    assign probe_last    = (cnt_inc == size_reg);
    assign rs_probe_last = (cnt_inc == rs_new_reg);
    assign rs_last       = (({1'b0, rs_idx_reg} + SIZE_W'(1)) == size_reg);
    assign live_dec      = (live_reg == '0) ? '0 : live_reg - SIZE_W'(1);

    // Load thresholds for doubling and halving
    assign live_x2   = {live_reg, 1'b0};
    assign size_x2   = {size_reg, 1'b0};
    assign dec_x8    = {live_dec, 3'b000};
    assign grow_ok   = auto_reg && (live_x2 >= {1'b0, size_reg})
                       && (size_x2 <= (SIZE_W + 1)'(MAX_SLOTS));
    assign shrink_ok = auto_reg && (dec_x8 <= {3'b000, size_reg}) && (size_reg > SIZE_W'(1));

    // One restoring step of key mod divisor, most significant key bit first
    assign mod_key  = (state_reg == ST_MOD_RS) ? rs_key_reg : key_reg;
    assign mod_t    = {rem_reg, mod_key[bit_reg]};
    assign mod_sub  = mod_t - {1'b0, div_reg};
    assign rem_step = (mod_t >= {1'b0, div_reg}) ? mod_sub[SIZE_W-1:0] : mod_t[SIZE_W-1:0];
    assign mod_last = (bit_reg == '0);

    // Resize walk steps to the next source slot
    assign rs_adv    = ((state_reg == ST_RS_CHK) && (act_tag != TAG_LIVE))
                       || ((state_reg == ST_RS_FCHK)
                           && ((dst_tag != TAG_LIVE) || rs_probe_last));

    assign init_wr = cfg_wr && (cfg_index == CFG_INITIAL_SIZE);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (clr_idx_reg == IDX_W'(MAX_SLOTS - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (cmd_valid)
                    state_next = (cmd.op == OP_NONE) ? ST_DONE : ST_MOD_OP;
            ST_MOD_OP:
                if (mod_last)
                    state_next = ST_LK_RD;
            ST_LK_RD:
                state_next = ST_LK_CHK;
            ST_LK_CHK:
                if (hit)
                    state_next = (op_reg == OP_DELETE && shrink_ok) ? ST_RS_RD : ST_DONE;
                else if (probe_last)
                    state_next = (op_reg == OP_INSERT && grow_ok) ? ST_RS_RD : ST_DONE;
                else
                    state_next = ST_LK_RD;
            ST_RS_RD:
                state_next = ST_RS_CHK;
            ST_RS_CHK:
                if (act_tag == TAG_LIVE)
                    state_next = ST_MOD_RS;
                else if (rs_last)
                    state_next = then_ins_reg ? ST_MOD_INS : ST_DONE;
                else
                    state_next = ST_RS_RD;
            ST_MOD_RS:
                if (mod_last)
                    state_next = ST_RS_FRD;
            ST_RS_FRD:
                state_next = ST_RS_FCHK;
            ST_RS_FCHK:
                if (dst_tag != TAG_LIVE || rs_probe_last)
                begin
                    if (rs_last)
                        state_next = then_ins_reg ? ST_MOD_INS : ST_DONE;
                    else
                        state_next = ST_RS_RD;
                end
                else
                    state_next = ST_RS_FRD;
            ST_MOD_INS:
                if (mod_last)
                    state_next = ST_FREE_RD;
            ST_FREE_RD:
                state_next = ST_FREE_CHK;
            ST_FREE_CHK:
                if (act_tag != TAG_LIVE || probe_last)
                    state_next = ST_DONE;
                else
                    state_next = ST_FREE_RD;
            ST_DONE:
                if (!res_full)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
        // A new table size restarts the clearing pass
        if (init_wr)
            state_next = ST_CLEAR;
    end

    // Datapath registers
    always_comb
    begin
        op_next         = op_reg;
        key_next        = key_reg;
        rs_key_next     = rs_key_reg;
        rem_next        = rem_reg;
        div_next        = div_reg;
        bit_next        = bit_reg;
        ptr_next        = ptr_reg;
        cnt_next        = cnt_reg;
        free_found_next = free_found_reg;
        free_ptr_next   = free_ptr_reg;
        rs_idx_next     = rs_idx_reg;
        rs_new_next     = rs_new_reg;
        rs_live_next    = rs_live_reg;
        then_ins_next   = then_ins_reg;
        clr_idx_next    = clr_idx_reg;
        bank_next       = bank_reg;
        size_next       = size_reg;
        live_next       = live_reg;
        grave_next      = grave_reg;
        auto_next       = auto_reg;
        succ_next       = succ_reg;
        slot_next       = slot_reg;
        fullerr_next    = fullerr_reg;

        case (state_reg) inside
            ST_CLEAR:
                clr_idx_next = clr_idx_reg + IDX_W'(1);
            ST_IDLE:
                if (cmd_valid)
                begin
                    op_next      = cmd.op;
                    key_next     = cmd.key;
                    rem_next     = '0;
                    bit_next     = BIT_W'(VALUE_BITS - 1);
                    div_next     = size_reg;
                    succ_next    = 1'b0;
                    slot_next    = '0;
                    fullerr_next = 1'b0;
                end
            ST_MOD_OP, ST_MOD_RS, ST_MOD_INS:
            begin
                rem_next = rem_step;
                bit_next = bit_reg - BIT_W'(1);
                if (mod_last)
                begin
                    ptr_next        = rem_step[IDX_W-1:0];
                    cnt_next        = '0;
                    free_found_next = 1'b0;
                end
            end
            ST_LK_CHK:
                if (hit)
                begin
                    slot_next = ptr_reg;
                    succ_next = (op_reg != OP_INSERT);
                    if (op_reg == OP_DELETE)
                    begin
                        live_next = live_dec;
                        if (grave_reg < SIZE_W'(MAX_SLOTS))
                            grave_next = grave_reg + SIZE_W'(1);
                        if (shrink_ok)
                        begin
                            rs_idx_next   = '0;
                            rs_new_next   = size_reg >> 1;
                            rs_live_next  = '0;
                            then_ins_next = 1'b0;
                        end
                    end
                end
                else
                begin
                    if (act_tag != TAG_LIVE && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_ptr_next   = ptr_reg;
                    end
                    if (probe_last)
                    begin
                        if (op_reg == OP_INSERT)
                        begin
                            if (grow_ok)
                            begin
                                rs_idx_next   = '0;
                                rs_new_next   = size_x2[SIZE_W-1:0];
                                rs_live_next  = '0;
                                then_ins_next = 1'b1;
                            end
                            else if (free_now)
                            begin
                                live_next = live_reg + SIZE_W'(1);
                                succ_next = 1'b1;
                                slot_next = free_sel;
                            end
                            else
                                fullerr_next = 1'b1;
                        end
                    end
                    else
                    begin
                        ptr_next = wrap_next(ptr_reg, size_reg);
                        cnt_next = cnt_inc;
                    end
                end
            ST_RS_CHK:
                if (act_tag == TAG_LIVE)
                begin
                    rs_key_next = act_key;
                    rem_next    = '0;
                    bit_next    = BIT_W'(VALUE_BITS - 1);
                    div_next    = rs_new_reg;
                end
            ST_RS_FCHK:
                if (dst_tag != TAG_LIVE)
                    rs_live_next = rs_live_reg + SIZE_W'(1);
                else if (!rs_probe_last)
                begin
                    ptr_next = wrap_next(ptr_reg, rs_new_reg);
                    cnt_next = cnt_inc;
                end
            ST_FREE_CHK:
                if (act_tag != TAG_LIVE)
                begin
                    live_next = live_reg + SIZE_W'(1);
                    succ_next = 1'b1;
                    slot_next = ptr_reg;
                end
                else if (probe_last)
                    fullerr_next = 1'b1;
                else
                begin
                    ptr_next = wrap_next(ptr_reg, size_reg);
                    cnt_next = cnt_inc;
                end
            default:
            begin
            end
        endcase

        // Advance the resize walk, or swap banks at its end
        if (rs_adv)
        begin
            if (rs_last)
            begin
                bank_next  = ~bank_reg;
                size_next  = rs_new_reg;
                live_next  = rs_live_next;
                grave_next = '0;
                rem_next   = '0;
                bit_next   = BIT_W'(VALUE_BITS - 1);
                div_next   = rs_new_reg;
            end
            else
                rs_idx_next = rs_idx_reg + IDX_W'(1);
        end

        // Configuration writes
        if (cfg_wr)
        begin
            unique case (cfg_index)
                CFG_AUTO_RESIZE:
                    auto_next = cfg_data[0];
                CFG_INITIAL_SIZE:
                begin
                    size_next    = clip_size(cfg_data);
                    bank_next    = 1'b0;
                    live_next    = '0;
                    grave_next   = '0;
                    clr_idx_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Memory ports and handshakes
    always_comb
    begin
        act_we    = 1'b0;
        act_waddr = ptr_reg;
        act_wdata = {TAG_LIVE, key_reg};
        act_raddr = ptr_reg;
        dst_we    = 1'b0;
        dst_waddr = ptr_reg;
        dst_wdata = {TAG_LIVE, rs_key_reg};
        dst_raddr = ptr_reg;
        clr_we    = 1'b0;
        cmd_take  = 1'b0;
        res_push  = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
                clr_we = 1'b1;
            ST_IDLE:
                cmd_take = cmd_valid;
            ST_LK_CHK:
                if (hit && op_reg == OP_DELETE)
                begin
                    act_we    = 1'b1;
                    act_wdata = {TAG_GRAVE, {VALUE_BITS{1'b0}}};
                end
                else if (!hit && probe_last && op_reg == OP_INSERT && !grow_ok && free_now)
                begin
                    act_we    = 1'b1;
                    act_waddr = free_sel;
                end
            ST_RS_RD:
                act_raddr = rs_idx_reg;
            ST_RS_CHK:
            begin
                act_we    = 1'b1;
                act_waddr = rs_idx_reg;
                act_wdata = EMPTY_SLOT;
            end
            ST_RS_FCHK:
                dst_we = (dst_tag != TAG_LIVE);
            ST_FREE_CHK:
                act_we = (act_tag != TAG_LIVE);
            ST_DONE:
                res_push = !res_full;
            default:
            begin
            end
        endcase
    end

    // Map logical ports onto the two physical banks
    assign a_we    = clr_we || (bank_reg ? dst_we : act_we);
    assign b_we    = clr_we || (bank_reg ? act_we : dst_we);
    assign a_waddr = clr_we ? clr_idx_reg : (bank_reg ? dst_waddr : act_waddr);
    assign b_waddr = clr_we ? clr_idx_reg : (bank_reg ? act_waddr : dst_waddr);
    assign a_wdata = clr_we ? EMPTY_SLOT : (bank_reg ? dst_wdata : act_wdata);
    assign b_wdata = clr_we ? EMPTY_SLOT : (bank_reg ? act_wdata : dst_wdata);
    assign a_raddr = bank_reg ? dst_raddr : act_raddr;
    assign b_raddr = bank_reg ? act_raddr : dst_raddr;

    always_ff @(posedge clk)
    begin
        if (a_we)
            bank_a_mem[a_waddr] <= a_wdata;
        a_q <= bank_a_mem[a_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
            bank_b_mem[b_waddr] <= b_wdata;
        b_q <= bank_b_mem[b_raddr];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
            bank_reg    <= 1'b0;
            size_reg    <= SIZE_W'(RESET_SIZE);
            live_reg    <= '0;
            grave_reg   <= '0;
            auto_reg    <= 1'b1;
        end
        else
        begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            bank_reg    <= bank_next;
            size_reg    <= size_next;
            live_reg    <= live_next;
            grave_reg   <= grave_next;
            auto_reg    <= auto_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        rs_key_reg     <= rs_key_next;
        rem_reg        <= rem_next;
        div_reg        <= div_next;
        bit_reg        <= bit_next;
        ptr_reg        <= ptr_next;
        cnt_reg        <= cnt_next;
        free_found_reg <= free_found_next;
        free_ptr_reg   <= free_ptr_next;
        rs_idx_reg     <= rs_idx_next;
        rs_new_reg     <= rs_new_next;
        rs_live_reg    <= rs_live_next;
        then_ins_reg   <= then_ins_next;
        succ_reg       <= succ_next;
        slot_reg       <= slot_next;
        fullerr_reg    <= fullerr_next;
    end

    assign res.success  = succ_reg;
    assign res.slot     = slot_reg;
    assign res.full_err = fullerr_reg;
    assign res.size     = size_reg;
    assign res.live     = live_reg;
    assign res.grave    = grave_reg;

endmodule

[rtl/linear_probe_hash_set.sv]
// Linear-probe hash set: one operation at a time. Each key is reduced mod the table size
// bit-serially, then slots are probed one at a time, up to the table size. A resize walks
// the old bank slot by slot and, for each live entry it moves, reduces the key mod the new
// size and probes the new bank for a free slot.
// Reset and every initial_size write start a clearing pass over all 1024 slots; up to two
// transactions queue meanwhile, then full rises until the pass ends.
// Depends on lphs_pkg, lphs_front, lphs_engine and lphs_resq.
module linear_probe_hash_set import lphs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [OPC_W-1:0]      operation,
    input  logic [VALUE_BITS-1:0] key_value,
    output logic                  empty,
    input  logic                  pop,
    output logic                  success,
    output logic [IDX_W-1:0]      slot_index,
    output logic                  full_error,
    output logic [SIZE_W-1:0]     table_size,
    output logic [SIZE_W-1:0]     element_count,
    output logic [SIZE_W-1:0]     tombstone_count,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_take;
    res_t res_eng;
    res_t res_out;
    logic res_push;
    logic res_full;

    assign cfg_ready = 1'b1;

    lphs_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .operation (operation),
        .key_value (key_value),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    lphs_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .res_push  (res_push),
        .res       (res_eng),
        .res_full  (res_full)
    );

    lphs_resq u_resq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_in   (res_eng),
        .res_full (res_full),
        .empty    (empty),
        .pop      (pop),
        .res_out  (res_out)
    );

    assign success         = res_out.success;
    assign slot_index      = res_out.slot;
    assign full_error      = res_out.full_err;
    assign table_size      = res_out.size;
    assign element_count   = res_out.live;
    assign tombstone_count = res_out.grave;

    // Table size of a waiting result stays in range
    a_size_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (table_size != '0 && table_size <= SIZE_W'(MAX_SLOTS)))
        else $error("table size out of range");

    // Live entries never exceed the table size
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (element_count <= table_size))
        else $error("element count exceeds table size");

    // A full-table insert reports no success and slot zero
    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && full_error) |-> (!success && slot_index == '0))
        else $error("full error with success or slot set");

endmodule
